>>> rtl/core/assert_macros.svh
// Assertion macros shared by the carver RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mdc_pkg.sv
// Types, constants and helper functions of the maze carver.
// Depends on nothing; used by mdc_seq and maze_dfs_carver_unit.
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

    localparam int COORD_W   = 6;
    localparam int DIM_LIMIT = 63;
    localparam int CELL_STEP = 2;
    localparam int NUM_DIRS  = 4;
    localparam int RESET_DIM = 37;
    localparam int UPC_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd1;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        C_FALL       = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NO_ACCEPT  = 4'd2,
        C_BEGIN      = 4'd3,
        C_DONE       = 4'd4,
        C_ANY        = 4'd5,
        C_LVL_ZERO   = 4'd6,
        C_NOT_CHOSEN = 4'd7,
        C_CLR_MORE   = 4'd8,
        C_OUT_BUSY   = 4'd9
    } t_cond;

    typedef struct packed {
        logic       operation;
        logic [1:0] direction;
    } t_item;

    typedef struct packed {
        logic               carved;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] wall_x;
        logic [COORD_W-1:0] wall_y;
        logic               backtracked;
        logic               finished;
    } t_result;

    typedef struct packed {
        logic             ready;
        logic             clr_rst;
        logic             clr_wr;
        logic             probe;
        t_dir             pdir;
        logic             stk_rd;
        logic             pop;
        logic             fin;
        logic             move;
        logic             init;
        logic             res_done;
        logic             emit;
        logic             ret;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_accept;
        logic is_begin;
        logic done;
        logic any;
        logic lvl_zero;
        logic not_chosen;
        logic clr_more;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_nbr;

    // Gives the cell two positions away in direction d and whether it lies in bounds.
    function automatic t_nbr nbr_of(t_dir d, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                    logic [COORD_W-1:0] cols, logic [COORD_W-1:0] rows);
        t_nbr           n;
        logic [COORD_W:0] x2;
        logic [COORD_W:0] y2;
        x2   = {1'b0, x} + (COORD_W + 1)'(CELL_STEP);
        y2   = {1'b0, y} + (COORD_W + 1)'(CELL_STEP);
        n.x  = x;
        n.y  = y;
        n.ok = 1'b0;
        unique case (d)
            DIR_LEFT: begin
                n.ok = (x >= COORD_W'(CELL_STEP));
                n.x  = x - COORD_W'(CELL_STEP);
            end
            DIR_RIGHT: begin
                n.ok = (x2 < {1'b0, cols});
                n.x  = x2[COORD_W-1:0];
            end
            DIR_UP: begin
                n.ok = (y >= COORD_W'(CELL_STEP));
                n.y  = y - COORD_W'(CELL_STEP);
            end
            DIR_DOWN: begin
                n.ok = (y2 < {1'b0, rows});
                n.y  = y2[COORD_W-1:0];
            end
            default: begin
                n.ok = 1'b0;
            end
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/maze_dfs_carver_unit.sv
// The maze carver top level: handshakes, the visited map and path stack, and the datapath.
// Depends on mdc_pkg, mdc_seq and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// The block carves a maze by randomised depth-first search, one transaction in and one
// result out per item. A step item probes the four neighbours one after another through
// the single read port of the visited map and then reads the path stack before its
// result; a step while finished stops after the second probe. A begin item sweeps the
// whole visited map, one entry a cycle, and the map depth is 1024 entries at the default
// MAX_DIM. A new item is taken in the cycle after the previous result is loaded into the
// output register, and configuration writes are accepted at any time.

`include "assert_macros.svh"

module maze_dfs_carver_unit
    import mdc_pkg::*;
#(
    parameter int MAX_DIM     = 63,
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_item                i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_result                   o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data
);

    localparam int EFF_MAX   = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
    localparam int HALF      = (EFF_MAX + 1) / 2;
    localparam int HB        = $clog2(HALF);
    localparam int MAP_AW    = 2 * HB;
    localparam int MAP_DEPTH = 1 << MAP_AW;
    localparam int CL_W      = $clog2(HALF * HALF);
    localparam int SB        = $clog2(STACK_DEPTH);
    localparam int LW        = $clog2(STACK_DEPTH + 1);
    localparam int ST_W      = 2 * COORD_W;

    localparam logic [COORD_W-1:0] EFF_MAX_C = COORD_W'(EFF_MAX);

    t_uword              uw;
    t_flags              flags;

    logic [COORD_W-1:0]  r_cols;
    logic [COORD_W-1:0]  r_rows;
    logic [COORD_W-1:0]  cols_eff;
    logic [COORD_W-1:0]  rows_eff;
    logic [COORD_W-1:0]  r_cx;
    logic [COORD_W-1:0]  r_cy;
    logic [LW-1:0]       r_level;
    logic [LW-1:0]       lvl_dec;
    logic [CL_W-1:0]     r_cells;
    logic [CL_W-1:0]     cells_dec;
    logic [CL_W-1:0]     init_cells;
    logic                r_done;
    logic                r_op;
    t_dir                r_dir;
    logic [NUM_DIRS-1:0] r_open;
    logic                r_probe_pend;
    t_dir                r_probe_dir;
    logic [MAP_AW-1:0]   r_clr_ptr;

    logic                r_map [MAP_DEPTH];
    logic                r_map_q;
    logic [ST_W-1:0]     r_stk [STACK_DEPTH];
    logic [ST_W-1:0]     r_stk_q;

    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;

    t_nbr                probe_nbr;
    t_nbr                cap_nbr;
    t_nbr                move_nbr;
    logic [MAP_AW-1:0]   probe_addr;
    logic [MAP_AW-1:0]   move_addr;
    logic                map_we;
    logic [MAP_AW-1:0]   map_waddr;
    logic                map_wdata;
    logic                push;
    logic                in_fire;
    logic                cfg_fire;
    logic                emit_fire;
    logic                dims_ok;
    logic [COORD_W-1:0]  half_c;
    logic [COORD_W-1:0]  half_r;
    logic [ST_W-1:0]     cell_prod;
    logic [COORD_W:0]    wall_sx;
    logic [COORD_W:0]    wall_sy;

    mdc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    assign o_in_ready  = uw.ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_fire   = i_in_valid & uw.ready;
    assign cfg_fire  = i_cfg_valid & o_cfg_ready;
    assign emit_fire = uw.emit & ~flags.out_busy;

    assign cols_eff = (r_cols > EFF_MAX_C) ? EFF_MAX_C : r_cols;
    assign rows_eff = (r_rows > EFF_MAX_C) ? EFF_MAX_C : r_rows;

    assign probe_nbr  = nbr_of(uw.pdir, r_cx, r_cy, cols_eff, rows_eff);
    assign cap_nbr    = nbr_of(r_probe_dir, r_cx, r_cy, cols_eff, rows_eff);
    assign move_nbr   = nbr_of(r_dir, r_cx, r_cy, cols_eff, rows_eff);
    assign probe_addr = {probe_nbr.y[HB:1], probe_nbr.x[HB:1]};
    assign move_addr  = {move_nbr.y[HB:1], move_nbr.x[HB:1]};

    assign lvl_dec   = r_level - LW'(1);
    assign cells_dec = (r_cells != '0) ? (r_cells - CL_W'(1)) : '0;
    assign push      = uw.move & (r_level < LW'(STACK_DEPTH));

    assign dims_ok    = (cols_eff != '0) & (rows_eff != '0);
    assign half_c     = COORD_W'(({1'b0, cols_eff} + (COORD_W + 1)'(1)) >> 1);
    assign half_r     = COORD_W'(({1'b0, rows_eff} + (COORD_W + 1)'(1)) >> 1);
    assign cell_prod  = ST_W'(half_c) * ST_W'(half_r);
    assign init_cells = dims_ok ? CL_W'(cell_prod - ST_W'(1)) : '0;

    assign wall_sx = {1'b0, r_cx} + {1'b0, move_nbr.x};
    assign wall_sy = {1'b0, r_cy} + {1'b0, move_nbr.y};

    assign flags.no_accept  = ~i_in_valid;
    assign flags.is_begin   = (r_op == OP_BEGIN);
    assign flags.done       = r_done;
    assign flags.any        = |r_open;
    assign flags.lvl_zero   = (r_level == '0);
    assign flags.not_chosen = ~r_open[r_dir];
    assign flags.clr_more   = (r_clr_ptr != '1);
    assign flags.out_busy   = r_out_valid & ~i_out_ready;

    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_clr_ptr;
        map_wdata = 1'b0;
        if (uw.clr_wr) begin
            map_we = 1'b1;
        end else if (uw.init) begin
            map_we    = dims_ok;
            map_waddr = '0;
            map_wdata = 1'b1;
        end else if (uw.move) begin
            map_we    = 1'b1;
            map_waddr = move_addr;
            map_wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (uw.probe) begin
            r_map_q <= r_map[probe_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stk[r_level[SB-1:0]] <= {r_cy, r_cx};
        end
        if (uw.stk_rd) begin
            r_stk_q <= r_stk[lvl_dec[SB-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols       <= COORD_W'(RESET_DIM);
            r_rows       <= COORD_W'(RESET_DIM);
            r_cx         <= '0;
            r_cy         <= '0;
            r_level      <= '0;
            r_cells      <= '0;
            r_done       <= 1'b1;
            r_probe_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_probe_pend <= uw.probe;
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_GRID_COLS: r_cols <= i_cfg_data;
                    CFG_GRID_ROWS: r_rows <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (uw.init) begin
                r_cx    <= '0;
                r_cy    <= '0;
                r_level <= '0;
                r_cells <= init_cells;
                r_done  <= (init_cells == '0);
            end
            if (uw.fin) begin
                r_done <= 1'b1;
            end
            if (uw.pop) begin
                r_level    <= lvl_dec;
                r_cy       <= r_stk_q[ST_W-1:COORD_W];
                r_cx       <= r_stk_q[COORD_W-1:0];
            end
            if (uw.move) begin
                if (push) begin
                    r_level <= r_level + LW'(1);
                end
                r_cx    <= move_nbr.x;
                r_cy    <= move_nbr.y;
                r_cells <= cells_dec;
                if (cells_dec == '0) begin
                    r_done <= 1'b1;
                end
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= i_in_data.operation;
            r_dir <= t_dir'(i_in_data.direction);
            r_res <= '0;
        end
        r_probe_dir <= uw.pdir;
        if (r_probe_pend) begin
            r_open[r_probe_dir] <= cap_nbr.ok & ~r_map_q;
        end
        if (uw.clr_rst) begin
            r_clr_ptr <= '0;
        end else if (uw.clr_wr) begin
            r_clr_ptr <= r_clr_ptr + MAP_AW'(1);
        end
        if (uw.fin) begin
            r_res.finished <= 1'b1;
        end
        if (uw.res_done) begin
            r_res.finished <= r_done;
        end
        if (uw.pop) begin
            r_res.backtracked <= 1'b1;
        end
        if (uw.move) begin
            r_res.carved <= 1'b1;
            r_res.cell_x <= move_nbr.x;
            r_res.cell_y <= move_nbr.y;
            r_res.wall_x <= wall_sx[COORD_W:1];
            r_res.wall_y <= wall_sy[COORD_W:1];
            if (cells_dec == '0) begin
                r_res.finished <= 1'b1;
            end
        end
        if (emit_fire) begin
            r_out <= r_res;
        end
    end

    `ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, r_level <= LW'(STACK_DEPTH), "stack level beyond depth")
    `ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, uw.pop, r_level != '0, "pop from an empty stack")
    `ASSERT_IMPLY(a_move_open, i_clk, i_rst_n, uw.move, r_open[r_dir], "move towards a closed neighbour")
    `ASSERT_IMPLY(a_cells_live, i_clk, i_rst_n, !r_done, r_cells != '0, "carving with no cells left")
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, emit_fire, r_out_valid, "emitted result not presented")

endmodule

`default_nettype wire

>>> rtl/core/mdc_seq.sv
// Microprogram sequencer of the maze carver: control store, step counter and jump logic.
// Depends on mdc_pkg for the control word, condition codes and status flags.
`timescale 1ns / 1ps
`default_nettype none

module mdc_seq
    import mdc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_uword      o_uword
);

    localparam logic [UPC_W-1:0] A_WAIT   = 4'd0;
    localparam logic [UPC_W-1:0] A_PROBE0 = 4'd1;
    localparam logic [UPC_W-1:0] A_PROBE1 = 4'd2;
    localparam logic [UPC_W-1:0] A_PROBE2 = 4'd3;
    localparam logic [UPC_W-1:0] A_PROBE3 = 4'd4;
    localparam logic [UPC_W-1:0] A_STKRD  = 4'd5;
    localparam logic [UPC_W-1:0] A_ANY    = 4'd6;
    localparam logic [UPC_W-1:0] A_EMPTY  = 4'd7;
    localparam logic [UPC_W-1:0] A_POP    = 4'd8;
    localparam logic [UPC_W-1:0] A_FIN    = 4'd9;
    localparam logic [UPC_W-1:0] A_CHOSEN = 4'd10;
    localparam logic [UPC_W-1:0] A_MOVE   = 4'd11;
    localparam logic [UPC_W-1:0] A_EMIT   = 4'd12;
    localparam logic [UPC_W-1:0] A_CLEAR  = 4'd13;
    localparam logic [UPC_W-1:0] A_INIT   = 4'd14;
    localparam logic [UPC_W-1:0] A_BEGRES = 4'd15;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    logic             cond_hit;

    function automatic t_uword rom_word(logic [UPC_W-1:0] addr);
        t_uword w;
        w      = '0;
        w.pdir = DIR_LEFT;
        w.cond = C_FALL;
        unique case (addr)
            A_WAIT: begin
                w.ready   = 1'b1;
                w.clr_rst = 1'b1;
                w.cond    = C_NO_ACCEPT;
                w.target  = A_WAIT;
            end
            A_PROBE0: begin
                w.probe  = 1'b1;
                w.pdir   = DIR_LEFT;
                w.cond   = C_BEGIN;
                w.target = A_CLEAR;
            end
            A_PROBE1: begin
                w.probe  = 1'b1;
                w.pdir   = DIR_RIGHT;
                w.cond   = C_DONE;
                w.target = A_FIN;
            end
            A_PROBE2: begin
                w.probe = 1'b1;
                w.pdir  = DIR_UP;
            end
            A_PROBE3: begin
                w.probe = 1'b1;
                w.pdir  = DIR_DOWN;
            end
            A_STKRD: begin
                w.stk_rd = 1'b1;
            end
            A_ANY: begin
                w.cond   = C_ANY;
                w.target = A_CHOSEN;
            end
            A_EMPTY: begin
                w.cond   = C_LVL_ZERO;
                w.target = A_FIN;
            end
            A_POP: begin
                w.pop    = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = A_EMIT;
            end
            A_FIN: begin
                w.fin    = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = A_EMIT;
            end
            A_CHOSEN: begin
                w.cond   = C_NOT_CHOSEN;
                w.target = A_EMIT;
            end
            A_MOVE: begin
                w.move = 1'b1;
            end
            A_EMIT: begin
                w.emit   = 1'b1;
                w.ret    = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = A_EMIT;
            end
            A_CLEAR: begin
                w.clr_wr = 1'b1;
                w.cond   = C_CLR_MORE;
                w.target = A_CLEAR;
            end
            A_INIT: begin
                w.init = 1'b1;
            end
            A_BEGRES: begin
                w.res_done = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = A_EMIT;
            end
            default: begin
                w.ret = 1'b1;
            end
        endcase
        return w;
    endfunction

    assign o_uword = rom_word(r_upc);

    always_comb begin
        unique case (o_uword.cond)
            C_FALL:       cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NO_ACCEPT:  cond_hit = i_flags.no_accept;
            C_BEGIN:      cond_hit = i_flags.is_begin;
            C_DONE:       cond_hit = i_flags.done;
            C_ANY:        cond_hit = i_flags.any;
            C_LVL_ZERO:   cond_hit = i_flags.lvl_zero;
            C_NOT_CHOSEN: cond_hit = i_flags.not_chosen;
            C_CLR_MORE:   cond_hit = i_flags.clr_more;
            C_OUT_BUSY:   cond_hit = i_flags.out_busy;
            default:      cond_hit = 1'b0;
        endcase
        if (cond_hit) begin
            n_upc = o_uword.target;
        end else if (o_uword.ret) begin
            n_upc = A_WAIT;
        end else begin
            n_upc = r_upc + UPC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

>>> bench/carve_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the maze carver: watches the item, result and register channels,
// predicts every result with its own model of the depth-first carver and compares.
// Depends on mdc_pkg.

module carve_checker
    import mdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire t_item                i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire t_result              i_out_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    localparam int HALF_SPAN  = (DIM_LIMIT + 1) / 2;
    localparam int MAP_SIZE   = HALF_SPAN * HALF_SPAN;
    localparam int PATH_DEPTH = 1024;

    bit                 visited [MAP_SIZE];
    logic [COORD_W-1:0] path_x [PATH_DEPTH];
    logic [COORD_W-1:0] path_y [PATH_DEPTH];
    int                 path_level;
    int                 here_x;
    int                 here_y;
    int                 cells_left;
    bit                 maze_done;
    int                 cols_reg;
    int                 rows_reg;
    t_result            awaited_carves [$];
    int                 mismatches = 0;

    function automatic int map_slot(int x, int y);
        return (y / CELL_STEP) * HALF_SPAN + x / CELL_STEP;
    endfunction

    function automatic int clamp_dim(int v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    function automatic bit free_neighbour(t_dir d, output int nx, output int ny);
        nx = here_x;
        ny = here_y;
        case (d)
            DIR_LEFT: begin
                if (here_x < CELL_STEP) return 0;
                nx = here_x - CELL_STEP;
            end
            DIR_RIGHT: begin
                if (here_x + CELL_STEP >= clamp_dim(cols_reg)) return 0;
                nx = here_x + CELL_STEP;
            end
            DIR_UP: begin
                if (here_y < CELL_STEP) return 0;
                ny = here_y - CELL_STEP;
            end
            default: begin
                if (here_y + CELL_STEP >= clamp_dim(rows_reg)) return 0;
                ny = here_y + CELL_STEP;
            end
        endcase
        return !visited[map_slot(nx, ny)];
    endfunction

    function automatic t_result carve_step(t_item it);
        t_result r;
        int      nx;
        int      ny;
        int      tx;
        int      ty;
        int      cols;
        int      rows;
        bit      any_free;
        r = '0;
        if (it.operation == OP_BEGIN) begin
            cols = clamp_dim(cols_reg);
            rows = clamp_dim(rows_reg);
            foreach (visited[i]) visited[i] = 0;
            path_level = 0;
            here_x     = 0;
            here_y     = 0;
            if (cols == 0 || rows == 0) begin
                cells_left = 0;
            end else begin
                visited[0] = 1;
                cells_left = ((cols + 1) / 2) * ((rows + 1) / 2) - 1;
            end
            maze_done  = (cells_left == 0);
            r.finished = maze_done;
            return r;
        end
        if (maze_done) begin
            r.finished = 1'b1;
            return r;
        end
        any_free = 0;
        for (int d = 0; d < NUM_DIRS; d++) begin
            if (free_neighbour(t_dir'(d), tx, ty)) any_free = 1;
        end
        if (!any_free) begin
            if (path_level == 0) begin
                maze_done  = 1;
                r.finished = 1'b1;
            end else begin
                path_level--;
                here_x        = path_x[path_level];
                here_y        = path_y[path_level];
                r.backtracked = 1'b1;
            end
            return r;
        end
        if (free_neighbour(t_dir'(it.direction), nx, ny)) begin
            if (path_level < PATH_DEPTH) begin
                path_x[path_level] = COORD_W'(here_x);
                path_y[path_level] = COORD_W'(here_y);
                path_level++;
            end
            r.wall_x = COORD_W'((here_x + nx) / 2);
            r.wall_y = COORD_W'((here_y + ny) / 2);
            here_x   = nx;
            here_y   = ny;
            visited[map_slot(nx, ny)] = 1;
            if (cells_left > 0) cells_left--;
            r.carved = 1'b1;
            r.cell_x = COORD_W'(nx);
            r.cell_y = COORD_W'(ny);
            if (cells_left == 0) begin
                maze_done  = 1;
                r.finished = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic string show(t_result r);
        return $sformatf("carved=%0d cell=(%0d,%0d) wall=(%0d,%0d) backtracked=%0d finished=%0d",
                         r.carved, r.cell_x, r.cell_y, r.wall_x, r.wall_y,
                         r.backtracked, r.finished);
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            foreach (visited[i]) visited[i] = 0;
            path_level = 0;
            here_x     = 0;
            here_y     = 0;
            cells_left = 0;
            maze_done  = 1;
            cols_reg   = RESET_DIM;
            rows_reg   = RESET_DIM;
            awaited_carves.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_carves.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with nothing awaited: %s", $time, show(i_out_data));
                    end
                end else begin
                    want = awaited_carves.pop_front();
                    bad  = (want.carved !== i_out_data.carved)
                        || (want.cell_x !== i_out_data.cell_x)
                        || (want.cell_y !== i_out_data.cell_y)
                        || (want.wall_x !== i_out_data.wall_x)
                        || (want.wall_y !== i_out_data.wall_y)
                        || (want.backtracked !== i_out_data.backtracked)
                        || (want.finished !== i_out_data.finished);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected %s", $time, show(want));
                            $display("%0t: actual   %s", $time, show(i_out_data));
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_COLS: cols_reg = i_cfg_data;
                    CFG_GRID_ROWS: rows_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                awaited_carves.push_back(carve_step(i_in_data));
            end
        end
        o_pending    = awaited_carves.size();
        o_mismatches = mismatches;
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the maze carver testbench: clock, reset, stimulus on the item and register
// channels, result back-pressure and the verdict. Depends on mdc_pkg, carve_checker
// and maze_dfs_carver_unit.

module tb;
    import mdc_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int ITEM_TARGET = 1300;
    localparam int LONG_HOLD   = 400;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_item                in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_result              out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data  = '0;

    int mismatches;
    int pending;
    int items_sent   = 0;
    int holds_asked  = 0;
    int holds_done   = 0;
    int quiet_cycles = 0;
    int cols_now     = RESET_DIM;
    int rows_now     = RESET_DIM;
    bit tx_idle      = 1;
    bit rx_idle      = 1;

    always #5 clk = ~clk;

    maze_dfs_carver_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    carve_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        @(posedge rst_n);
        forever begin
            if (holds_done < holds_asked) begin
                gap = LONG_HOLD;
                holds_done++;
            end else begin
                gap = rx_idle ? $urandom_range(0, 8) : 0;
            end
            if ($urandom_range(0, 59) == 0) rx_idle = !rx_idle;
            @(negedge clk);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic offer(logic op, logic [1:0] dir);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 49) == 0) tx_idle = !tx_idle;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid            = 1'b1;
        in_data.operation   = op;
        in_data.direction   = dir;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = COORD_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_GRID_COLS) cols_now = value;
        else rows_now = value;
    endtask

    task automatic new_maze(int c, int r);
        settle();
        write_reg(CFG_GRID_COLS, c);
        write_reg(CFG_GRID_ROWS, r);
        offer(OP_BEGIN, 2'($urandom_range(0, 3)));
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return DIM_LIMIT;
            2, 3:    return $urandom_range(17, DIM_LIMIT);
            default: return $urandom_range(1, 13);
        endcase
    endfunction

    initial begin : stimulus
        int steps;
        int cells;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // A step straight after reset finds the carver finished.
        offer(OP_STEP, DIR_LEFT);
        offer(OP_BEGIN, DIR_DOWN);
        offer(OP_STEP, DIR_UP);
        offer(OP_STEP, DIR_LEFT);
        offer(OP_STEP, DIR_RIGHT);
        offer(OP_STEP, DIR_DOWN);
        // Shrinking the grid mid-maze leaves dead ends that unwind the whole stack.
        settle();
        write_reg(CFG_GRID_COLS, 3);
        write_reg(CFG_GRID_ROWS, 3);
        offer(OP_STEP, DIR_LEFT);
        offer(OP_STEP, DIR_DOWN);
        offer(OP_STEP, DIR_RIGHT);
        offer(OP_STEP, DIR_UP);
        offer(OP_STEP, DIR_LEFT);
        offer(OP_STEP, DIR_DOWN);
        new_maze(1, 1);
        offer(OP_STEP, DIR_RIGHT);
        new_maze(0, 1);
        new_maze(DIM_LIMIT, 0);
        new_maze(DIM_LIMIT, 1);
        offer(OP_STEP, DIR_RIGHT);
        offer(OP_STEP, DIR_RIGHT);
        offer(OP_STEP, DIR_LEFT);
        new_maze(2, DIM_LIMIT);
        offer(OP_STEP, DIR_DOWN);
        offer(OP_STEP, DIR_RIGHT);
        offer(OP_STEP, DIR_DOWN);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) begin
                settle();
                if ($urandom_range(0, 1) == 0) write_reg(CFG_GRID_COLS, pick_dim());
                else write_reg(CFG_GRID_ROWS, pick_dim());
            end else if ($urandom_range(0, 3) == 0) begin
                offer(OP_BEGIN, 2'($urandom_range(0, 3)));
            end else begin
                new_maze(pick_dim(), pick_dim());
            end
            cells = ((cols_now + 1) / 2) * ((rows_now + 1) / 2);
            if (cells > 100) steps = $urandom_range(20, 60);
            else steps = $urandom_range(4, 4 * cells + 8);
            if (steps > 160) steps = 160;
            if ((holds_asked == 0 && items_sent >= 500)
                    || (holds_asked == 1 && items_sent >= 1000)) begin
                holds_asked++;
            end
            repeat (steps) begin
                if ($urandom_range(0, 39) == 0) offer(OP_BEGIN, 2'($urandom_range(0, 3)));
                else offer(OP_STEP, 2'($urandom_range(0, 3)));
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
